// ===== rtl/lr_table_parse_engine_unit_macros.svh =====
// Assertion macros shared by the parse engine RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LR_TABLE_PARSE_ENGINE_UNIT_MACROS_SVH
`define LR_TABLE_PARSE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRPE_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lrpe_pkg.sv =====
// Shared types and codes of the LR table parse engine.
// No dependencies; used by every module of the engine.
package lrpe_pkg;

    localparam int FIELD_W = 13;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_TOKEN   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [2:0] SEL_ACTION    = 3'd0;
    localparam logic [2:0] SEL_ROW_START = 3'd1;
    localparam logic [2:0] SEL_GOTO      = 3'd2;
    localparam logic [2:0] SEL_GOTO_ROW  = 3'd3;
    localparam logic [2:0] SEL_LHS       = 3'd4;
    localparam logic [2:0] SEL_LENGTH    = 3'd5;

    localparam logic [2:0] EV_SHIFT   = 3'd0;
    localparam logic [2:0] EV_REDUCE  = 3'd1;
    localparam logic [2:0] EV_ACCEPT  = 3'd2;
    localparam logic [2:0] EV_ABORT   = 3'd3;
    localparam logic [2:0] EV_SYNTAX  = 3'd4;
    localparam logic [2:0] EV_DISCARD = 3'd5;
    localparam logic [2:0] EV_LIMIT   = 3'd6;
    localparam logic [2:0] EV_LOADED  = 3'd7;

    localparam logic [2:0] ACT_SHIFT  = 3'd0;
    localparam logic [2:0] ACT_REDUCE = 3'd1;
    localparam logic [2:0] ACT_ACCEPT = 3'd2;
    localparam logic [2:0] ACT_ERROR  = 3'd3;

    localparam logic [15:0] DEFAULT_MARK = 16'hFC18;
    localparam logic [15:0] END_TOKEN    = 16'hFFFF;

    localparam int GOTO_ROWS   = 512;
    localparam int GOTO_ROWS_W = 9;
    localparam logic [6:0] MAX_RES   = 7'd64;
    localparam logic [6:0] LAST_MID  = 7'd63;

    typedef struct packed {
        logic [2:0]  sel;
        logic [11:0] addr;
        logic [15:0] data;
    } ld_t;

    typedef struct packed {
        logic [2:0]         ev;
        logic [FIELD_W-1:0] val;
        logic               last;
    } res_t;

endpackage

// ===== rtl/lr_table_parse_engine_unit.sv =====
// LR table parse engine, top level: stream ports, output register, submodules.
// Instantiates lrpe_tables, lrpe_stack and lrpe_ctrl; depends on lrpe_pkg.
//
// A load beat writes one table word and answers one load-done beat. A token
// beat runs the parse sequencer, one table or stack memory read per cycle
// while the output side does not stall it: it fetches a state's action row and
// scans its action pairs, reads a production and walks its goto pairs for each
// reduction, and while unwinding after an error reads each stack entry and tries
// its action pairs; a closing step ends the item. A restart beat answers nothing.
// Results leave through a one-beat output register, and the sequencer holds one
// result back until it knows whether it is the last, so the engine only stalls
// when two results wait on a blocked master side.
// Table memories are not cleared at reset; a word must be loaded before use.
module lr_table_parse_engine_unit #(
    parameter int STACK_DEPTH  = 256,
    parameter int ACTION_WORDS = 4096,
    parameter int GOTO_WORDS   = 2048,
    parameter int PRODUCTIONS  = 1024,
    parameter int STATES       = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // table_select, table_address, table_data, token
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // value
    output logic [2:0]  m_tuser,   // event_res
    output logic        m_tlast
);

    localparam int AIW = $clog2(ACTION_WORDS);
    localparam int GIW = $clog2(GOTO_WORDS);
    localparam int PIW = $clog2(PRODUCTIONS);
    localparam int SIW = $clog2(STATES);
    localparam int KIW = $clog2(STACK_DEPTH);

    lrpe_pkg::ld_t  in_ld;
    lrpe_pkg::ld_t  ld;
    lrpe_pkg::res_t out_res;
    logic           out_push, out_free, ld_en, rd_en;
    logic [AIW-1:0] act_ra;
    logic [SIW-1:0] row_ra;
    logic [GIW-1:0] goto_ra;
    logic [lrpe_pkg::GOTO_ROWS_W-1:0] grow_ra;
    logic [PIW-1:0] prod_ra;
    logic [15:0]    act_rd, goto_rd;
    logic [11:0]    row_rd;
    logic [10:0]    grow_rd;
    logic [8:0]     lhs_rd;
    logic [7:0]     len_rd;
    logic           stk_we;
    logic [KIW-1:0] stk_wa, stk_ra;
    logic [lrpe_pkg::FIELD_W-1:0] stk_wd, stk_rd;

    logic           m_valid_reg;
    lrpe_pkg::res_t m_res_reg;

    assign in_ld.sel  = s_tdata[2:0];
    assign in_ld.addr = s_tdata[14:3];
    assign in_ld.data = s_tdata[30:15];

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_push) m_res_reg <= out_res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_res_reg.val};
    assign m_tuser  = m_res_reg.ev;
    assign m_tlast  = m_res_reg.last;

    lrpe_tables #(
        .ACTION_WORDS(ACTION_WORDS),
        .GOTO_WORDS  (GOTO_WORDS),
        .PRODUCTIONS (PRODUCTIONS),
        .STATES      (STATES)
    ) u_tables (
        .aclk   (aclk),
        .ld_en  (ld_en),
        .ld     (ld),
        .rd_en  (rd_en),
        .act_ra (act_ra),
        .row_ra (row_ra),
        .goto_ra(goto_ra),
        .grow_ra(grow_ra),
        .prod_ra(prod_ra),
        .act_rd (act_rd),
        .row_rd (row_rd),
        .goto_rd(goto_rd),
        .grow_rd(grow_rd),
        .lhs_rd (lhs_rd),
        .len_rd (len_rd)
    );

    lrpe_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk (aclk),
        .we   (stk_we),
        .wa   (stk_wa),
        .wd   (stk_wd),
        .rd_en(rd_en),
        .ra   (stk_ra),
        .rd   (stk_rd)
    );

    lrpe_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .ACTION_WORDS(ACTION_WORDS),
        .GOTO_WORDS  (GOTO_WORDS),
        .PRODUCTIONS (PRODUCTIONS),
        .STATES      (STATES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_kind (s_tuser),
        .in_ld   (in_ld),
        .in_token(s_tdata[43:31]),
        .out_free(out_free),
        .out_push(out_push),
        .out_res (out_res),
        .ld_en   (ld_en),
        .ld      (ld),
        .rd_en   (rd_en),
        .act_ra  (act_ra),
        .row_ra  (row_ra),
        .goto_ra (goto_ra),
        .grow_ra (grow_ra),
        .prod_ra (prod_ra),
        .act_rd  (act_rd),
        .row_rd  (row_rd),
        .goto_rd (goto_rd),
        .grow_rd (grow_rd),
        .lhs_rd  (lhs_rd),
        .len_rd  (len_rd),
        .stk_we  (stk_we),
        .stk_wa  (stk_wa),
        .stk_wd  (stk_wd),
        .stk_ra  (stk_ra),
        .stk_rd  (stk_rd)
    );

endmodule

// ===== rtl/lrpe_tables.sv =====
// Parse table memories: actions, row starts, gotos, goto starts, lhs, lengths.
// One write port fed by load beats, registered reads; depends on lrpe_pkg.
module lrpe_tables #(
    parameter int ACTION_WORDS = 4096,
    parameter int GOTO_WORDS   = 2048,
    parameter int PRODUCTIONS  = 1024,
    parameter int STATES       = 1024,
    localparam int AIW = $clog2(ACTION_WORDS),
    localparam int GIW = $clog2(GOTO_WORDS),
    localparam int PIW = $clog2(PRODUCTIONS),
    localparam int SIW = $clog2(STATES)
) (
    input  logic                aclk,
    input  logic                ld_en,
    input  lrpe_pkg::ld_t       ld,
    input  logic                rd_en,
    input  logic [AIW-1:0]      act_ra,
    input  logic [SIW-1:0]      row_ra,
    input  logic [GIW-1:0]      goto_ra,
    input  logic [lrpe_pkg::GOTO_ROWS_W-1:0] grow_ra,
    input  logic [PIW-1:0]      prod_ra,
    output logic [15:0]         act_rd,
    output logic [11:0]         row_rd,
    output logic [15:0]         goto_rd,
    output logic [10:0]         grow_rd,
    output logic [8:0]          lhs_rd,
    output logic [7:0]          len_rd
);

    logic [15:0] act_mem  [ACTION_WORDS];
    logic [11:0] row_mem  [STATES];
    logic [15:0] goto_mem [GOTO_WORDS];
    logic [10:0] grow_mem [lrpe_pkg::GOTO_ROWS];
    logic [8:0]  lhs_mem  [PRODUCTIONS];
    logic [7:0]  len_mem  [PRODUCTIONS];

    logic [15:0] act_rd_reg;
    logic [11:0] row_rd_reg;
    logic [15:0] goto_rd_reg;
    logic [10:0] grow_rd_reg;
    logic [8:0]  lhs_rd_reg;
    logic [7:0]  len_rd_reg;

    logic act_we, row_we, goto_we, grow_we, lhs_we, len_we;

    // Loads beyond a table's depth are dropped.
    assign act_we  = ld_en && (ld.sel == lrpe_pkg::SEL_ACTION)
                     && (int'(ld.addr) < ACTION_WORDS);
    assign row_we  = ld_en && (ld.sel == lrpe_pkg::SEL_ROW_START)
                     && (int'(ld.addr) < STATES);
    assign goto_we = ld_en && (ld.sel == lrpe_pkg::SEL_GOTO)
                     && (int'(ld.addr) < GOTO_WORDS);
    assign grow_we = ld_en && (ld.sel == lrpe_pkg::SEL_GOTO_ROW)
                     && (int'(ld.addr) < lrpe_pkg::GOTO_ROWS);
    assign lhs_we  = ld_en && (ld.sel == lrpe_pkg::SEL_LHS)
                     && (int'(ld.addr) < PRODUCTIONS);
    assign len_we  = ld_en && (ld.sel == lrpe_pkg::SEL_LENGTH)
                     && (int'(ld.addr) < PRODUCTIONS);

    always_ff @(posedge aclk) begin
        if (act_we) act_mem[AIW'(ld.addr)] <= ld.data;
        if (rd_en) act_rd_reg <= act_mem[act_ra];
    end

    always_ff @(posedge aclk) begin
        if (row_we) row_mem[SIW'(ld.addr)] <= ld.data[11:0];
        if (rd_en) row_rd_reg <= row_mem[row_ra];
    end

    always_ff @(posedge aclk) begin
        if (goto_we) goto_mem[GIW'(ld.addr)] <= ld.data;
        if (rd_en) goto_rd_reg <= goto_mem[goto_ra];
    end

    always_ff @(posedge aclk) begin
        if (grow_we) grow_mem[ld.addr[lrpe_pkg::GOTO_ROWS_W-1:0]] <= ld.data[10:0];
        if (rd_en) grow_rd_reg <= grow_mem[grow_ra];
    end

    always_ff @(posedge aclk) begin
        if (lhs_we) lhs_mem[PIW'(ld.addr)] <= ld.data[8:0];
        if (rd_en) lhs_rd_reg <= lhs_mem[prod_ra];
    end

    always_ff @(posedge aclk) begin
        if (len_we) len_mem[PIW'(ld.addr)] <= ld.data[7:0];
        if (rd_en) len_rd_reg <= len_mem[prod_ra];
    end

    assign act_rd  = act_rd_reg;
    assign row_rd  = row_rd_reg;
    assign goto_rd = goto_rd_reg;
    assign grow_rd = grow_rd_reg;
    assign lhs_rd  = lhs_rd_reg;
    assign len_rd  = len_rd_reg;

endmodule

// ===== rtl/lrpe_stack.sv =====
// State stack memory of the parse engine, one write and one registered read.
// The bottom entry always reads as state zero; depends on lrpe_pkg.
module lrpe_stack #(
    parameter int STACK_DEPTH = 256,
    localparam int KIW = $clog2(STACK_DEPTH)
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [KIW-1:0]               wa,
    input  logic [lrpe_pkg::FIELD_W-1:0] wd,
    input  logic                         rd_en,
    input  logic [KIW-1:0]               ra,
    output logic [lrpe_pkg::FIELD_W-1:0] rd
);

    logic [lrpe_pkg::FIELD_W-1:0] stk_mem [STACK_DEPTH];
    logic [lrpe_pkg::FIELD_W-1:0] rd_data_reg;
    logic                         rd_bottom_reg;

    always_ff @(posedge aclk) begin
        if (we) stk_mem[wa] <= wd;
        if (rd_en) begin
            rd_data_reg   <= stk_mem[ra];
            rd_bottom_reg <= (ra == '0);
        end
    end

    assign rd = rd_bottom_reg ? '0 : rd_data_reg;

endmodule

// ===== rtl/lrpe_ctrl.sv =====
// Parse sequencer: walks action and goto rows, reduces, recovers from errors.
// Drives lrpe_tables and lrpe_stack, holds one result back to mark the last
// beat; depends on lrpe_pkg and the assertion macro header.
`include "lr_table_parse_engine_unit_macros.svh"
module lrpe_ctrl #(
    parameter int STACK_DEPTH  = 256,
    parameter int ACTION_WORDS = 4096,
    parameter int GOTO_WORDS   = 2048,
    parameter int PRODUCTIONS  = 1024,
    parameter int STATES       = 1024,
    localparam int AIW = $clog2(ACTION_WORDS),
    localparam int GIW = $clog2(GOTO_WORDS),
    localparam int PIW = $clog2(PRODUCTIONS),
    localparam int SIW = $clog2(STATES),
    localparam int KIW = $clog2(STACK_DEPTH),
    localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_kind,
    input  lrpe_pkg::ld_t       in_ld,
    input  logic [12:0]         in_token,
    input  logic                out_free,
    output logic                out_push,
    output lrpe_pkg::res_t      out_res,
    output logic                ld_en,
    output lrpe_pkg::ld_t       ld,
    output logic                rd_en,
    output logic [AIW-1:0]      act_ra,
    output logic [SIW-1:0]      row_ra,
    output logic [GIW-1:0]      goto_ra,
    output logic [lrpe_pkg::GOTO_ROWS_W-1:0] grow_ra,
    output logic [PIW-1:0]      prod_ra,
    input  logic [15:0]         act_rd,
    input  logic [11:0]         row_rd,
    input  logic [15:0]         goto_rd,
    input  logic [10:0]         grow_rd,
    input  logic [8:0]          lhs_rd,
    input  logic [7:0]          len_rd,
    output logic                stk_we,
    output logic [KIW-1:0]      stk_wa,
    output logic [lrpe_pkg::FIELD_W-1:0] stk_wd,
    output logic [KIW-1:0]      stk_ra,
    input  logic [lrpe_pkg::FIELD_W-1:0] stk_rd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_ROW   = 5'd1;
    localparam logic [4:0] ST_ROWD  = 5'd2;
    localparam logic [4:0] ST_CHK   = 5'd3;
    localparam logic [4:0] ST_ACT   = 5'd4;
    localparam logic [4:0] ST_RED1  = 5'd5;
    localparam logic [4:0] ST_RED2  = 5'd6;
    localparam logic [4:0] ST_GCHK  = 5'd7;
    localparam logic [4:0] ST_GNS   = 5'd8;
    localparam logic [4:0] ST_GPUSH = 5'd9;
    localparam logic [4:0] ST_ERR   = 5'd10;
    localparam logic [4:0] ST_ERR2  = 5'd11;
    localparam logic [4:0] ST_UNW   = 5'd12;
    localparam logic [4:0] ST_UNW1  = 5'd13;
    localparam logic [4:0] ST_UNW2  = 5'd14;
    localparam logic [4:0] ST_DP1   = 5'd15;
    localparam logic [4:0] ST_DP2   = 5'd16;
    localparam logic [4:0] ST_DONE  = 5'd17;

    localparam int FW = lrpe_pkg::FIELD_W;
    localparam logic [16:0] A_LAST = 17'(ACTION_WORDS - 1);
    localparam logic [16:0] G_LAST = 17'(GOTO_WORDS - 1);

    logic [4:0]     st_reg, st_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [FW-1:0]  cur_reg, cur_next;
    logic [1:0]     err_reg, err_next;
    logic           fin_reg, fin_next;
    logic [15:0]    la_reg, la_next;
    logic           la_none_reg, la_none_next;
    logic [6:0]     res_n_reg, res_n_next;
    logic [16:0]    p_reg, p_next;
    logic           match_reg, match_next;
    logic [SPW-1:0] i_reg, i_next;
    logic [FW-1:0]  prod_reg, prod_next;
    logic [FW-1:0]  top_reg, top_next;
    logic [FW-1:0]  ns_reg, ns_next;
    logic           pend_v_reg, pend_v_next;
    lrpe_pkg::res_t pend_reg, pend_next;

    logic           stall;
    logic           do_put;
    logic [2:0]     put_ev;
    logic [FW-1:0]  put_val;

    assign stall    = pend_v_reg && !out_free;
    assign rd_en    = !stall;
    assign in_ready = (st_reg == ST_IDLE);
    assign ld       = in_ld;
    assign ld_en    = in_valid && in_ready && (in_kind == lrpe_pkg::KIND_LOAD);

    always_comb begin
        logic [16:0] p2;
        logic [2:0]  code;
        logic [FW-1:0] field;
        logic [SPW-1:0] sp_red;
        logic la_end;

        st_next      = st_reg;
        sp_next      = sp_reg;
        cur_next     = cur_reg;
        err_next     = err_reg;
        fin_next     = fin_reg;
        la_next      = la_reg;
        la_none_next = la_none_reg;
        res_n_next   = res_n_reg;
        p_next       = p_reg;
        match_next   = match_reg;
        i_next       = i_reg;
        prod_next    = prod_reg;
        top_next     = top_reg;
        ns_next      = ns_reg;
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        out_push     = 1'b0;
        out_res      = pend_reg;
        act_ra       = '0;
        row_ra       = '0;
        goto_ra      = '0;
        grow_ra      = '0;
        prod_ra      = '0;
        stk_we       = 1'b0;
        stk_wa       = '0;
        stk_wd       = '0;
        stk_ra       = '0;
        do_put       = 1'b0;
        put_ev       = lrpe_pkg::EV_ABORT;
        put_val      = '0;
        p2           = p_reg + 17'd2;
        code         = act_rd[15:13];
        field        = act_rd[FW-1:0];
        sp_red       = sp_reg - SPW'(len_rd);
        la_end       = !la_none_reg && (la_reg == lrpe_pkg::END_TOKEN);

        if (!stall) begin
            case (st_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        case (in_kind)
                            lrpe_pkg::KIND_LOAD: begin
                                do_put  = 1'b1;
                                put_ev  = lrpe_pkg::EV_LOADED;
                                st_next = ST_DONE;
                            end
                            lrpe_pkg::KIND_TOKEN: begin
                                if (fin_reg) begin
                                    do_put  = 1'b1;
                                    put_ev  = lrpe_pkg::EV_ABORT;
                                    st_next = ST_DONE;
                                end else begin
                                    la_next      = (in_token == '0) ? lrpe_pkg::END_TOKEN
                                                                     : {3'b000, in_token};
                                    la_none_next = 1'b0;
                                    st_next      = ST_ROW;
                                end
                            end
                            lrpe_pkg::KIND_RESTART: begin
                                sp_next  = SPW'(1);
                                cur_next = '0;
                                err_next = '0;
                                fin_next = 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ROW: begin
                    if (int'(cur_reg) >= STATES) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_ABORT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        row_ra  = SIW'(cur_reg);
                        st_next = ST_ROWD;
                    end
                end
                ST_ROWD: begin
                    if ({5'd0, row_rd} >= A_LAST) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_ABORT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        act_ra     = AIW'({5'd0, row_rd} + 17'd1);
                        p_next     = {5'd0, row_rd};
                        st_next    = ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (act_rd == lrpe_pkg::DEFAULT_MARK) begin
                        match_next = 1'b0;
                        act_ra     = AIW'(p_reg);
                        st_next    = ST_ACT;
                    end else if (la_none_reg) begin
                        // The row needs a lookahead and this beat's token is used up.
                        st_next = ST_DONE;
                    end else if (act_rd == la_reg) begin
                        match_next = 1'b1;
                        act_ra     = AIW'(p_reg);
                        st_next    = ST_ACT;
                    end else if (p2 >= A_LAST) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_ABORT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        act_ra     = AIW'(p2 + 17'd1);
                        p_next     = p2;
                    end
                end
                ST_ACT: begin
                    if (code == lrpe_pkg::ACT_SHIFT && match_reg) begin
                        if (int'(sp_reg) >= STACK_DEPTH) begin
                            do_put = 1'b1; put_ev = lrpe_pkg::EV_LIMIT;
                            fin_next = 1'b1; st_next = ST_DONE;
                        end else begin
                            stk_we   = 1'b1;
                            stk_wa   = KIW'(sp_reg);
                            stk_wd   = field;
                            sp_next  = sp_reg + SPW'(1);
                            cur_next = field;
                            if (err_reg != '0) err_next = err_reg - 2'd1;
                            if (!la_end) begin
                                do_put = 1'b1; put_ev = lrpe_pkg::EV_SHIFT;
                                put_val = field; st_next = ST_DONE;
                            end else if (res_n_reg >= lrpe_pkg::LAST_MID) begin
                                do_put = 1'b1; put_ev = lrpe_pkg::EV_LIMIT;
                                fin_next = 1'b1; st_next = ST_DONE;
                            end else begin
                                do_put = 1'b1; put_ev = lrpe_pkg::EV_SHIFT;
                                put_val = field; st_next = ST_ROW;
                            end
                        end
                    end else if (code == lrpe_pkg::ACT_REDUCE) begin
                        if (int'(field) >= PRODUCTIONS) begin
                            do_put = 1'b1; put_ev = lrpe_pkg::EV_ABORT;
                            fin_next = 1'b1; st_next = ST_DONE;
                        end else begin
                            prod_ra   = PIW'(field);
                            prod_next = field;
                            st_next   = ST_RED1;
                        end
                    end else if (code == lrpe_pkg::ACT_ACCEPT) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_ACCEPT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else if (code > lrpe_pkg::ACT_ERROR) begin
                        do_put = 1'b1;
                        put_ev = (err_reg == '0) ? lrpe_pkg::EV_ACCEPT : lrpe_pkg::EV_ABORT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        st_next = ST_ERR;
                    end
                end
                ST_RED1: begin
                    if (int'(len_rd) >= int'(sp_reg)) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_ABORT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        sp_next = sp_red;
                        stk_ra  = KIW'(sp_red - SPW'(1));
                        grow_ra = lhs_rd[lrpe_pkg::GOTO_ROWS_W-1:0];
                        st_next = ST_RED2;
                    end
                end
                ST_RED2: begin
                    top_next = stk_rd;
                    p_next   = {6'd0, grow_rd};
                    if ({6'd0, grow_rd} >= G_LAST) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_ABORT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        goto_ra = GIW'(grow_rd);
                        st_next = ST_GCHK;
                    end
                end
                ST_GCHK: begin
                    if (goto_rd == {3'b000, top_reg} || goto_rd == lrpe_pkg::DEFAULT_MARK) begin
                        goto_ra = GIW'(p_reg + 17'd1);
                        st_next = ST_GNS;
                    end else if (p2 >= G_LAST) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_ABORT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        goto_ra = GIW'(p2);
                        p_next  = p2;
                    end
                end
                ST_GNS: begin
                    ns_next = goto_rd[FW-1:0];
                    if (res_n_reg >= lrpe_pkg::LAST_MID) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_LIMIT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_REDUCE;
                        put_val = prod_reg; st_next = ST_GPUSH;
                    end
                end
                ST_GPUSH: begin
                    if (int'(sp_reg) >= STACK_DEPTH) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_LIMIT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        stk_we   = 1'b1;
                        stk_wa   = KIW'(sp_reg);
                        stk_wd   = ns_reg;
                        sp_next  = sp_reg + SPW'(1);
                        cur_next = ns_reg;
                        st_next  = ST_ROW;
                    end
                end
                ST_ERR: begin
                    if (err_reg != '0) begin
                        st_next = ST_ERR2;
                    end else if (res_n_reg >= lrpe_pkg::LAST_MID) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_LIMIT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_SYNTAX;
                        st_next = ST_ERR2;
                    end
                end
                ST_ERR2: begin
                    if (err_reg != 2'd3) begin
                        err_next = 2'd3;
                        i_next   = sp_reg;
                        st_next  = ST_UNW;
                    end else if (la_end) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_ABORT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else if (res_n_reg >= lrpe_pkg::LAST_MID) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_LIMIT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_DISCARD;
                        la_none_next = 1'b1;
                        st_next = ST_ROW;
                    end
                end
                ST_UNW: begin
                    if (i_reg == '0) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_ABORT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        stk_ra  = KIW'(i_reg - SPW'(1));
                        st_next = ST_UNW1;
                    end
                end
                ST_UNW1: begin
                    if (int'(stk_rd) >= STATES) begin
                        i_next  = i_reg - SPW'(1);
                        st_next = ST_UNW;
                    end else begin
                        row_ra  = SIW'(stk_rd);
                        st_next = ST_UNW2;
                    end
                end
                ST_UNW2: begin
                    if ({5'd0, row_rd} >= A_LAST) begin
                        i_next  = i_reg - SPW'(1);
                        st_next = ST_UNW;
                    end else begin
                        act_ra  = AIW'({5'd0, row_rd} + 17'd1);
                        p_next  = {5'd0, row_rd};
                        st_next = ST_DP1;
                    end
                end
                ST_DP1: begin
                    if (act_rd == lrpe_pkg::DEFAULT_MARK) begin
                        act_ra  = AIW'(p_reg);
                        st_next = ST_DP2;
                    end else if (p2 >= A_LAST) begin
                        i_next  = i_reg - SPW'(1);
                        st_next = ST_UNW;
                    end else begin
                        act_ra = AIW'(p2 + 17'd1);
                        p_next = p2;
                    end
                end
                ST_DP2: begin
                    if (code != lrpe_pkg::ACT_SHIFT) begin
                        i_next  = i_reg - SPW'(1);
                        st_next = ST_UNW;
                    end else if (int'(i_reg) >= STACK_DEPTH) begin
                        do_put = 1'b1; put_ev = lrpe_pkg::EV_LIMIT;
                        fin_next = 1'b1; st_next = ST_DONE;
                    end else begin
                        // Cut the stack back to this state and shift its default.
                        stk_we   = 1'b1;
                        stk_wa   = KIW'(i_reg);
                        stk_wd   = field;
                        sp_next  = i_reg + SPW'(1);
                        cur_next = field;
                        st_next  = ST_ROW;
                    end
                end
                ST_DONE: begin
                    out_push      = pend_v_reg;
                    out_res       = pend_reg;
                    out_res.last  = 1'b1;
                    pend_v_next   = 1'b0;
                    res_n_next    = '0;
                    st_next       = ST_IDLE;
                end
                default: begin
                    st_next = ST_IDLE;
                end
            endcase

            // A new result releases the held one as a non-final beat.
            if (do_put && res_n_reg < lrpe_pkg::MAX_RES) begin
                if (pend_v_reg) begin
                    out_push     = 1'b1;
                    out_res      = pend_reg;
                    out_res.last = 1'b0;
                end
                pend_v_next   = 1'b1;
                pend_next.ev  = put_ev;
                pend_next.val = put_val;
                pend_next.last = 1'b0;
                res_n_next    = res_n_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            sp_reg      <= SPW'(1);
            cur_reg     <= '0;
            err_reg     <= '0;
            fin_reg     <= 1'b0;
            la_none_reg <= 1'b0;
            res_n_reg   <= '0;
            pend_v_reg  <= 1'b0;
            match_reg   <= 1'b0;
        end else begin
            st_reg      <= st_next;
            sp_reg      <= sp_next;
            cur_reg     <= cur_next;
            err_reg     <= err_next;
            fin_reg     <= fin_next;
            la_none_reg <= la_none_next;
            res_n_reg   <= res_n_next;
            pend_v_reg  <= pend_v_next;
            match_reg   <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        la_reg   <= la_next;
        p_reg    <= p_next;
        i_reg    <= i_next;
        prod_reg <= prod_next;
        top_reg  <= top_next;
        ns_reg   <= ns_next;
        pend_reg <= pend_next;
    end

    `LRPE_ASSERT_IMPLY(a_push_has_room, aclk, aresetn, out_push, out_free,
        "result beat pushed into a full output register")
    `LRPE_ASSERT_IMPLY(a_idle_empty, aclk, aresetn, in_ready,
        !pend_v_reg && res_n_reg == '0, "idle with a result still held")
    `LRPE_ASSERT_IMPLY(a_sp_bound, aclk, aresetn, 1'b1, int'(sp_reg) <= STACK_DEPTH,
        "stack pointer beyond stack depth")
    `LRPE_ASSERT_IMPLY(a_res_bound, aclk, aresetn, 1'b1, res_n_reg <= lrpe_pkg::MAX_RES,
        "more results than the limit")
    `LRPE_ASSERT_NEXT(a_done_idle, aclk, aresetn, st_reg == ST_DONE && !stall,
        st_reg == ST_IDLE, "item end did not return to idle")

endmodule

// ===== tb/lr_table_parse_engine_checker.sv =====
// Scoreboard for the LR table parse engine: watches both stream channels,
// predicts the result beats of every accepted input beat and compares them.
// Depends on lrpe_pkg for codes and the result layout.
`timescale 1ns / 1ps

module lr_table_parse_engine_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);

    localparam int N_ACTION = 4096;
    localparam int N_GOTO   = 2048;
    localparam int N_PROD   = 1024;
    localparam int N_STATE  = 1024;
    localparam int N_STACK  = 256;
    localparam int NO_TOK   = 'h10000;
    localparam int RES_CAP  = 64;

    logic [15:0] act_tab [N_ACTION];
    logic [11:0] row_st  [N_STATE];
    logic [15:0] goto_tab[N_GOTO];
    logic [10:0] goto_st [lrpe_pkg::GOTO_ROWS];
    logic [8:0]  lhs_tab [N_PROD];
    logic [7:0]  len_tab [N_PROD];
    logic [12:0] stk     [N_STACK];
    int          sp;
    int          cur;
    int          err_lvl;
    bit          parse_over;

    lrpe_pkg::res_t beat_res[$];
    lrpe_pkg::res_t want_q[$];

    function automatic void put_res(logic [2:0] ev, logic [12:0] val);
        lrpe_pkg::res_t r;
        if (beat_res.size() < RES_CAP) begin
            r.ev = ev;
            r.val = val;
            r.last = 1'b0;
            beat_res.push_back(r);
        end
    endfunction

    function automatic void end_parse(logic [2:0] ev);
        put_res(ev, '0);
        parse_over = 1'b1;
    endfunction

    // Only the 64th beat may be a consuming shift or a terminal event.
    function automatic bit put_mid(logic [2:0] ev, logic [12:0] val);
        if (beat_res.size() >= RES_CAP - 1) begin
            end_parse(lrpe_pkg::EV_LIMIT);
            return 1'b0;
        end
        put_res(ev, val);
        return 1'b1;
    endfunction

    function automatic bit push_state(int s);
        if (sp >= N_STACK) return 1'b0;
        stk[sp] = s[12:0];
        sp++;
        cur = s & 'h1FFF;
        return 1'b1;
    endfunction

    function automatic void restart_parse();
        foreach (stk[i]) stk[i] = '0;
        sp = 0;
        void'(push_state(0));
        err_lvl = 0;
        parse_over = 1'b0;
    endfunction

    function automatic int default_pair(int p);
        while (p + 1 < N_ACTION) begin
            if (act_tab[p+1] == lrpe_pkg::DEFAULT_MARK) return p;
            p += 2;
        end
        return -1;
    endfunction

    function automatic void parse_token(int la);
        int          p, len, top, g, ns, i, d, s;
        logic [15:0] word;
        logic [2:0]  code;
        logic [12:0] field;
        bit          matched, found;
        while (1) begin
            if (cur >= N_STATE) begin end_parse(lrpe_pkg::EV_ABORT); return; end
            p = row_st[cur];
            if (p + 1 >= N_ACTION) begin end_parse(lrpe_pkg::EV_ABORT); return; end
            if (act_tab[p+1] != lrpe_pkg::DEFAULT_MARK) begin
                if (la == NO_TOK) return;
                while (act_tab[p+1] != lrpe_pkg::DEFAULT_MARK && int'(act_tab[p+1]) != la)
                begin
                    p += 2;
                    if (p + 1 >= N_ACTION) begin end_parse(lrpe_pkg::EV_ABORT); return; end
                end
            end
            word = act_tab[p];
            matched = act_tab[p+1] != lrpe_pkg::DEFAULT_MARK;
            code = word[15:13];
            field = word[12:0];

            if (code == lrpe_pkg::ACT_SHIFT && matched) begin
                if (!push_state(field)) begin end_parse(lrpe_pkg::EV_LIMIT); return; end
                if (err_lvl > 0) err_lvl--;
                if (la != int'(lrpe_pkg::END_TOKEN)) begin
                    put_res(lrpe_pkg::EV_SHIFT, field);
                    return;
                end
                if (!put_mid(lrpe_pkg::EV_SHIFT, field)) return;
                continue;
            end
            if (code == lrpe_pkg::ACT_REDUCE) begin
                if (field >= N_PROD) begin end_parse(lrpe_pkg::EV_ABORT); return; end
                len = len_tab[field];
                if (len >= sp) begin end_parse(lrpe_pkg::EV_ABORT); return; end
                sp -= len;
                top = stk[sp-1];
                g = goto_st[lhs_tab[field] % lrpe_pkg::GOTO_ROWS];
                while (1) begin
                    if (g + 1 >= N_GOTO) begin end_parse(lrpe_pkg::EV_ABORT); return; end
                    if (int'(goto_tab[g]) == top || goto_tab[g] == lrpe_pkg::DEFAULT_MARK)
                        break;
                    g += 2;
                end
                ns = goto_tab[g+1] & 'h1FFF;
                if (!put_mid(lrpe_pkg::EV_REDUCE, field)) return;
                if (!push_state(ns)) begin end_parse(lrpe_pkg::EV_LIMIT); return; end
                continue;
            end
            if (code == lrpe_pkg::ACT_ACCEPT) begin end_parse(lrpe_pkg::EV_ACCEPT); return; end
            if (code > lrpe_pkg::ACT_ERROR) begin
                end_parse(err_lvl == 0 ? lrpe_pkg::EV_ACCEPT : lrpe_pkg::EV_ABORT);
                return;
            end

            // Syntax error, either an error entry or a shift reached by default.
            if (err_lvl == 0) begin
                if (!put_mid(lrpe_pkg::EV_SYNTAX, '0)) return;
            end
            if (err_lvl < 3) begin
                i = sp;
                found = 1'b0;
                err_lvl = 3;
                while (i > 0 && !found) begin
                    s = stk[i-1];
                    if (s < N_STATE) begin
                        d = default_pair(row_st[s]);
                        if (d >= 0 && act_tab[d][15:13] == lrpe_pkg::ACT_SHIFT) begin
                            sp = i;
                            if (!push_state(act_tab[d][12:0])) begin
                                end_parse(lrpe_pkg::EV_LIMIT);
                                return;
                            end
                            found = 1'b1;
                        end
                    end
                    if (!found) i--;
                end
                if (!found) begin end_parse(lrpe_pkg::EV_ABORT); return; end
            end else begin
                if (la == int'(lrpe_pkg::END_TOKEN)) begin
                    end_parse(lrpe_pkg::EV_ABORT);
                    return;
                end
                if (!put_mid(lrpe_pkg::EV_DISCARD, '0)) return;
                la = NO_TOK;
            end
        end
    endfunction

    function automatic void predict_beat(logic [1:0] kind, logic [47:0] d);
        logic [2:0]  sel;
        logic [11:0] addr;
        logic [15:0] data;
        logic [12:0] tok;
        lrpe_pkg::res_t r;
        sel = d[2:0];
        addr = d[14:3];
        data = d[30:15];
        tok = d[43:31];
        beat_res.delete();
        case (kind)
            lrpe_pkg::KIND_LOAD: begin
                case (sel)
                    lrpe_pkg::SEL_ACTION:    act_tab[addr] = data;
                    lrpe_pkg::SEL_ROW_START: if (addr < N_STATE) row_st[addr] = data[11:0];
                    lrpe_pkg::SEL_GOTO:      if (addr < N_GOTO) goto_tab[addr] = data;
                    lrpe_pkg::SEL_GOTO_ROW:
                        if (addr < lrpe_pkg::GOTO_ROWS) goto_st[addr] = data[10:0];
                    lrpe_pkg::SEL_LHS:       if (addr < N_PROD) lhs_tab[addr] = data[8:0];
                    lrpe_pkg::SEL_LENGTH:    if (addr < N_PROD) len_tab[addr] = data[7:0];
                    default: ;
                endcase
                put_res(lrpe_pkg::EV_LOADED, '0);
            end
            lrpe_pkg::KIND_TOKEN: begin
                if (parse_over) put_res(lrpe_pkg::EV_ABORT, '0);
                else parse_token(tok == 0 ? int'(lrpe_pkg::END_TOKEN) : int'(tok));
            end
            lrpe_pkg::KIND_RESTART: restart_parse();
            default: ;
        endcase
        foreach (beat_res[i]) begin
            r = beat_res[i];
            r.last = (i == beat_res.size() - 1);
            want_q.push_back(r);
        end
    endfunction

    always @(posedge aclk) begin
        lrpe_pkg::res_t w;
        if (!aresetn) begin
            restart_parse();
            want_q.delete();
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (want_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result beat ev=%0d value=%0d last=%0b",
                                 $realtime, m_tuser, m_tdata, m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    w = want_q.pop_front();
                    if (m_tuser !== w.ev || m_tdata !== {3'b000, w.val} || m_tlast !== w.last)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: result beat mismatch: expected ev=%0d value=%0d ",
                                      "last=%0b, got ev=%0d value=%0d last=%0b"},
                                     $realtime, w.ev, w.val, w.last,
                                     m_tuser, m_tdata, m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= want_q.size();
    end

endmodule

// ===== tb/tb_lr_table_parse_engine_unit.sv =====
// Top of the parse engine testbench: clock, reset, stimulus and verdict.
// Loads a small expression grammar, then drives directed and random beats;
// instantiates lr_table_parse_engine_unit and lr_table_parse_engine_checker.
`timescale 1ns / 1ps

module tb_lr_table_parse_engine_unit;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int TOTAL_ITEMS     = 450;

    // Codes outside the defined sets, to reach the ignore and unknown paths.
    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam logic [2:0] SEL_SPARE_LO = 3'd6;
    localparam logic [2:0] SEL_SPARE_HI = 3'd7;
    localparam logic [2:0] ACT_SPARE    = 3'd5;

    // Grammar: E -> E + a | a, plus recovery, a self-looping empty rule
    // and some broken entries to reach the abort paths.
    localparam logic [12:0] T_A     = 13'd1;
    localparam logic [12:0] T_PLUS  = 13'd2;
    localparam logic [12:0] T_END   = 13'd0;
    localparam logic [12:0] T_BADOP = 13'd7;
    localparam logic [12:0] T_FAR   = 13'd8;
    localparam logic [12:0] T_NEST  = 13'd9;
    localparam logic [12:0] T_BADP  = 13'd6;
    localparam logic [12:0] T_LOOP  = 13'd10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;

    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    bit          nested = 1'b0;
    int          stall_left = 0;
    int          sent = 0;
    int          idle_cycles = 0;

    lr_table_parse_engine_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    lr_table_parse_engine_checker scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .fail_count(fail_count), .pending(pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: short random stalls, one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            stall_left <= 300;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(input logic [1:0] kind, input logic [2:0] sel,
                        input logic [11:0] addr, input logic [15:0] data,
                        input logic [12:0] tok);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tdata <= {4'b0000, tok, data, addr, sel};
        s_tuser <= kind;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic load(input logic [2:0] sel, input logic [11:0] addr,
                        input logic [15:0] data);
        send(lrpe_pkg::KIND_LOAD, sel, addr, data, 13'($urandom));
    endtask

    task automatic act_pair(input logic [11:0] addr, input logic [2:0] code,
                            input logic [12:0] field, input logic [15:0] tok);
        load(lrpe_pkg::SEL_ACTION, addr, {code, field});
        load(lrpe_pkg::SEL_ACTION, addr + 12'd1, tok);
    endtask

    // Unused fields carry random bits so every bit toggles.
    task automatic token(input logic [12:0] t);
        send(lrpe_pkg::KIND_TOKEN, 3'($urandom), 12'($urandom), 16'($urandom), t);
    endtask

    task automatic restart();
        send(lrpe_pkg::KIND_RESTART, 3'($urandom), 12'($urandom), 16'($urandom),
             13'($urandom));
    endtask

    // Loads that never touch the grammar's words.
    task automatic scratch_load();
        logic [2:0]  sel;
        logic [11:0] addr;
        sel = 3'($urandom);
        addr = 12'($urandom);
        case (sel)
            lrpe_pkg::SEL_ACTION:    addr[11] = 1'b1;
            lrpe_pkg::SEL_ROW_START: addr[9] = 1'b1;
            lrpe_pkg::SEL_GOTO:      addr[10] = 1'b1;
            lrpe_pkg::SEL_GOTO_ROW:  addr[8] = 1'b1;
            lrpe_pkg::SEL_LHS, lrpe_pkg::SEL_LENGTH: addr[9] = 1'b1;
            default: ;
        endcase
        load(sel, addr, 16'($urandom));
    endtask

    function automatic logic [12:0] pick_special();
        case ($urandom_range(0, 7))
            0: return T_BADOP;
            1: return T_FAR;
            2: return T_NEST;
            3: return T_BADP;
            4: return T_LOOP;
            5: return T_END;
            default: return 13'($urandom_range(11, 8191));
        endcase
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        act_pair(12'd0,  lrpe_pkg::ACT_SHIFT,  13'd2,    {3'd0, T_A});
        act_pair(12'd2,  lrpe_pkg::ACT_SHIFT,  13'd5,    lrpe_pkg::DEFAULT_MARK);
        act_pair(12'd4,  lrpe_pkg::ACT_SHIFT,  13'd3,    {3'd0, T_PLUS});
        act_pair(12'd6,  lrpe_pkg::ACT_ACCEPT, 13'd0,    lrpe_pkg::END_TOKEN);
        act_pair(12'd8,  ACT_SPARE,            13'd0,    {3'd0, T_BADOP});
        act_pair(12'd10, lrpe_pkg::ACT_SHIFT,  13'd6,    {3'd0, T_LOOP});
        act_pair(12'd12, lrpe_pkg::ACT_ERROR,  13'd0,    lrpe_pkg::DEFAULT_MARK);
        act_pair(12'd14, lrpe_pkg::ACT_REDUCE, 13'd1,    lrpe_pkg::DEFAULT_MARK);
        act_pair(12'd16, lrpe_pkg::ACT_SHIFT,  13'd4,    {3'd0, T_A});
        act_pair(12'd18, lrpe_pkg::ACT_REDUCE, 13'd2000, {3'd0, T_BADP});
        act_pair(12'd20, lrpe_pkg::ACT_SHIFT,  13'd3000, {3'd0, T_FAR});
        act_pair(12'd22, lrpe_pkg::ACT_SHIFT,  13'd3,    {3'd0, T_NEST});
        act_pair(12'd24, lrpe_pkg::ACT_ERROR,  13'd0,    lrpe_pkg::DEFAULT_MARK);
        act_pair(12'd26, lrpe_pkg::ACT_REDUCE, 13'd0,    lrpe_pkg::DEFAULT_MARK);
        act_pair(12'd28, lrpe_pkg::ACT_REDUCE, 13'd2,    lrpe_pkg::DEFAULT_MARK);
        act_pair(12'd30, lrpe_pkg::ACT_REDUCE, 13'd3,    lrpe_pkg::DEFAULT_MARK);
        load(lrpe_pkg::SEL_ROW_START, 12'd0, 16'd0);
        load(lrpe_pkg::SEL_ROW_START, 12'd1, 16'd4);
        load(lrpe_pkg::SEL_ROW_START, 12'd2, 16'd14);
        load(lrpe_pkg::SEL_ROW_START, 12'd3, 16'd16);
        load(lrpe_pkg::SEL_ROW_START, 12'd4, 16'd26);
        load(lrpe_pkg::SEL_ROW_START, 12'd5, 16'd28);
        load(lrpe_pkg::SEL_ROW_START, 12'd6, 16'd30);
        load(lrpe_pkg::SEL_GOTO, 12'd0, 16'd0);
        load(lrpe_pkg::SEL_GOTO, 12'd1, 16'd1);
        load(lrpe_pkg::SEL_GOTO, 12'd2, lrpe_pkg::DEFAULT_MARK);
        load(lrpe_pkg::SEL_GOTO, 12'd3, 16'd1);
        load(lrpe_pkg::SEL_GOTO, 12'd4, lrpe_pkg::DEFAULT_MARK);
        load(lrpe_pkg::SEL_GOTO, 12'd5, 16'd6);
        load(lrpe_pkg::SEL_GOTO_ROW, 12'd0, 16'd0);
        load(lrpe_pkg::SEL_GOTO_ROW, 12'd1, 16'd4);
        load(lrpe_pkg::SEL_LHS, 12'd0, 16'd0);
        load(lrpe_pkg::SEL_LHS, 12'd1, 16'd0);
        load(lrpe_pkg::SEL_LHS, 12'd2, 16'd0);
        load(lrpe_pkg::SEL_LHS, 12'd3, 16'd1);
        load(lrpe_pkg::SEL_LENGTH, 12'd0, 16'd3);
        load(lrpe_pkg::SEL_LENGTH, 12'd1, 16'd1);
        load(lrpe_pkg::SEL_LENGTH, 12'd2, 16'd1);
        load(lrpe_pkg::SEL_LENGTH, 12'd3, 16'd0);

        // Directed: out-of-range loads, ignored kind, and each parse path.
        load(SEL_SPARE_LO, 12'hFFF, 16'h8000);
        load(SEL_SPARE_HI, 12'h000, 16'h7FFF);
        load(lrpe_pkg::SEL_GOTO_ROW, 12'hFFF, 16'hFFFF);
        load(lrpe_pkg::SEL_LENGTH, 12'hFFF, 16'h0000);
        send(KIND_SPARE, lrpe_pkg::SEL_ACTION, 12'd0, 16'd0, 13'h1FFF);
        token(T_A); token(T_PLUS); token(T_A); token(T_END);
        token(13'h1FFF);
        restart(); token(T_END);
        restart(); token(T_A); token(13'd5); token(13'd5); token(T_PLUS); token(T_A);
        token(T_END);
        restart(); token(T_A); token(T_PLUS); token(T_FAR); token(T_A);
        restart(); token(T_A); token(T_PLUS); token(T_BADP);
        restart(); token(T_A); token(T_LOOP); token(T_A);
        restart(); token(T_A); token(T_BADOP);
        restart();

        hold_req = 1'b1;
        while (sent < TOTAL_ITEMS) begin
            if (sent > TOTAL_ITEMS - 60) quiet = 1'b1;
            if (sent >= 150 && !nested) begin
                // Nest until the state stack overflows.
                nested = 1'b1;
                restart(); token(T_A); token(T_PLUS);
                repeat (258) token(T_NEST);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    restart();
                    token(T_A);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(0, 7) == 0) token(pick_special());
                        else begin
                            token(T_PLUS);
                            token(T_A);
                        end
                    end
                    if ($urandom_range(0, 5) != 0) token(T_END);
                end
                6: begin
                    token(13'($urandom));
                end
                7: begin
                    token(pick_special());
                end
                8: begin
                    scratch_load();
                end
                default: begin
                    if ($urandom_range(0, 1) == 0) restart();
                    else send(KIND_SPARE, 3'($urandom), 12'($urandom), 16'($urandom),
                              13'($urandom));
                end
            endcase
        end
        s_tvalid <= 1'b0;
        quiet = 1'b1;

        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
